>>> rtl/pst_pkg.sv
// Package for the paced semaphore table: default sizes, field widths,
// command codes and the control and status structs between the modules.
// No dependencies.
package pst_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF = 16;

    // At most this many fire words are reported for one consume command.
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W   = 3;
    localparam int ENTRY_W = 4;
    localparam int VAL_W   = 16;
    localparam int MODE_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SETUP   = 3'd0,
        CMD_GIVE    = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_CONSUME = 3'd5
    } cmd_t;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EX    = 3'b010,
        S_FINAL = 3'b100
    } state_t;

    // Operation applied to the entry record that was just read.
    typedef struct packed {
        cmd_t              cmd;
        logic [MODE_W-1:0] mode;
        logic              allow_fire;
    } ctrl_t;

    // What the update did to that entry.
    typedef struct packed {
        logic fire;
        logic refused;
    } upd_t;

endpackage

>>> rtl/pst_mem.sv
// Entry store of the paced semaphore table: one synchronous memory with a
// registered read port and per-entry valid bits so that reset reads as zero.
// Depends on nothing but its parameters.
module pst_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 66,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written since reset holds its reset value of zero.
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

>>> rtl/pst_alu.sv
// Entry update of the paced semaphore table: applies one command to one
// entry record read from the store. Depends on pst_pkg.
module pst_alu
    import pst_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  ctrl_t                                  ctrl,
    input  logic [2*COUNT_BITS+2*TIMER_BITS+1:0]   rec_in,
    input  logic [VAL_W-1:0]                       start_count,
    input  logic [VAL_W-1:0]                       ceiling,
    input  logic [VAL_W-1:0]                       reload_ticks,
    output logic [2*COUNT_BITS+2*TIMER_BITS+1:0]   rec_out,
    output upd_t                                   upd
);

    localparam int REC_W = 2*COUNT_BITS + 2*TIMER_BITS + 2;

    logic [COUNT_BITS-1:0] cnt, ceil_v, cnt_n, ceil_n, cnt_dec;
    logic [TIMER_BITS-1:0] tmr, rld, tmr_n, rld_n, tmr_dec;
    logic                  run, rdy, run_n, rdy_n;
    logic [31:0]           start_w, ceil_w, reload_w;

    assign cnt    = rec_in[COUNT_BITS-1:0];
    assign ceil_v = rec_in[2*COUNT_BITS-1:COUNT_BITS];
    assign tmr    = rec_in[2*COUNT_BITS+TIMER_BITS-1:2*COUNT_BITS];
    assign rld    = rec_in[2*COUNT_BITS+2*TIMER_BITS-1:2*COUNT_BITS+TIMER_BITS];
    assign rdy    = rec_in[REC_W-2];
    assign run    = rec_in[REC_W-1];

    assign start_w  = 32'(start_count);
    assign ceil_w   = 32'(ceiling);
    assign reload_w = 32'(reload_ticks);
    assign cnt_dec  = cnt - COUNT_BITS'(1);
    assign tmr_dec  = tmr - TIMER_BITS'(1);

    always_comb
    begin
        cnt_n       = cnt;
        ceil_n      = ceil_v;
        tmr_n       = tmr;
        rld_n       = rld;
        run_n       = run;
        rdy_n       = rdy;
        upd.fire    = 1'b0;
        upd.refused = 1'b0;
        unique case (ctrl.cmd)
            CMD_SETUP:
            begin
                cnt_n  = start_w[COUNT_BITS-1:0];
                ceil_n = ceil_w[COUNT_BITS-1:0];
                rld_n  = reload_w[TIMER_BITS-1:0];
                tmr_n  = reload_w[TIMER_BITS-1:0];
                run_n  = 1'b0;
                rdy_n  = 1'b0;
            end
            CMD_GIVE:
            begin
                if (cnt < ceil_v)
                begin
                    cnt_n = cnt + COUNT_BITS'(1);
                    if (ctrl.mode == MODE_SET)
                    begin
                        run_n = 1'b1;
                    end
                    else if (ctrl.mode == MODE_CLEAR)
                    begin
                        run_n = 1'b0;
                    end
                end
                else
                begin
                    upd.refused = 1'b1;
                end
            end
            CMD_ENABLE:
            begin
                run_n = 1'b1;
            end
            CMD_DISABLE:
            begin
                run_n = 1'b0;
            end
            CMD_TICK:
            begin
                // A timer already at zero is stuck and never makes the entry ready.
                if (run && !rdy && (tmr != '0))
                begin
                    if (tmr_dec == '0)
                    begin
                        rdy_n = 1'b1;
                        tmr_n = rld;
                    end
                    else
                    begin
                        tmr_n = tmr_dec;
                    end
                end
            end
            CMD_CONSUME:
            begin
                if (ctrl.allow_fire && run && rdy && (cnt != '0))
                begin
                    upd.fire = 1'b1;
                    cnt_n    = cnt_dec;
                    rdy_n    = 1'b0;
                    if (cnt_dec == '0)
                    begin
                        run_n = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rec_out = {run_n, rdy_n, rld_n, tmr_n, ceil_n, cnt_n};

endmodule

>>> rtl/paced_semaphore_table.sv
// Paced semaphore table. Setup, give, enable and disable act on one entry: the
// entry is read from the store, then updated and written back in the update state,
// and the single result word is registered from the final state. Tick and consume
// sweep every entry through the one read port of the store, one entry per cycle
// while no fire is held back. Any command is held up while the output side stalls
// and one of its words waits to be handed over. The store needs no clearing pass
// after reset. A new command word is taken only once the previous command has
// placed its last word in the output register.
// Depends on pst_pkg, pst_mem and pst_alu.
module paced_semaphore_table
    import pst_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [VAL_W-1:0]   start_count,
    input  logic [VAL_W-1:0]   ceiling,
    input  logic [VAL_W-1:0]   reload_ticks,
    input  logic [MODE_W-1:0]  open_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ENTRY_W-1:0] fired_entry,
    output logic               fired,
    output logic               status,
    output logic [VAL_W-1:0]   remaining,
    output logic               last
);

    localparam int REC_W = 2*COUNT_BITS + 2*TIMER_BITS + 2;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [VAL_W-1:0]      start_reg, start_next;
    logic [VAL_W-1:0]      ceil_reg, ceil_next;
    logic [VAL_W-1:0]      reload_reg, reload_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    logic                  hold_valid_reg, hold_valid_next;
    logic [ENTRY_W-1:0]    hold_entry_reg, hold_entry_next;
    logic                  hold_fired_reg, hold_fired_next;
    logic                  hold_status_reg, hold_status_next;
    logic [VAL_W-1:0]      hold_rem_reg, hold_rem_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0]    out_entry_reg, out_entry_next;
    logic                  out_fired_reg, out_fired_next;
    logic                  out_status_reg, out_status_next;
    logic [VAL_W-1:0]      out_rem_reg, out_rem_next;
    logic                  out_last_reg, out_last_next;

    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [REC_W-1:0]      rec_rd, rec_wr;
    ctrl_t                 ctrl;
    upd_t                  upd;

    logic                  accept, out_free, sweep, ex_stall;
    logic [7:0]            ent_w, idx_w;
    logic [31:0]           rem_w;
    logic                  in_range;

    pst_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (REC_W),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rec_rd),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (rec_wr)
    );

    pst_alu #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_alu (
        .ctrl         (ctrl),
        .rec_in       (rec_rd),
        .start_count  (start_reg),
        .ceiling      (ceil_reg),
        .reload_ticks (reload_reg),
        .rec_out      (rec_wr),
        .upd          (upd)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign sweep    = (cmd_reg == CMD_TICK) || (cmd_reg == CMD_CONSUME);

    assign ent_w    = 8'(entry);
    assign idx_w    = 8'(idx_reg);
    assign rem_w    = 32'(rec_wr[COUNT_BITS-1:0]);
    assign in_range = (32'(entry) < 32'(ENTRIES));

    assign ctrl.cmd        = cmd_reg;
    assign ctrl.mode       = mode_reg;
    assign ctrl.allow_fire = (32'(fire_cnt_reg) < 32'(MAX_RESULTS));

    // A fire must wait when the previous fire word still sits in the hold
    // register and the output register cannot take it yet.
    assign ex_stall = upd.fire && hold_valid_reg && !out_free;
    assign wr_en    = (state_reg == S_EX) && !ex_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        mode_next        = mode_reg;
        start_next       = start_reg;
        ceil_next        = ceil_reg;
        reload_next      = reload_reg;
        idx_next         = idx_reg;
        fire_cnt_next    = fire_cnt_reg;
        hold_valid_next  = hold_valid_reg;
        hold_entry_next  = hold_entry_reg;
        hold_fired_next  = hold_fired_reg;
        hold_status_next = hold_status_reg;
        hold_rem_next    = hold_rem_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_entry_next   = out_entry_reg;
        out_fired_next   = out_fired_reg;
        out_status_next  = out_status_reg;
        out_rem_next     = out_rem_reg;
        out_last_next    = out_last_reg;
        rd_addr          = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = cmd_t'(command);
                    mode_next        = open_mode;
                    start_next       = start_count;
                    ceil_next        = ceiling;
                    reload_next      = reload_ticks;
                    fire_cnt_next    = '0;
                    hold_valid_next  = 1'b0;
                    hold_entry_next  = entry;
                    hold_fired_next  = 1'b0;
                    hold_status_next = 1'b0;
                    hold_rem_next    = '0;
                    unique case (command)
                        CMD_TICK, CMD_CONSUME:
                        begin
                            idx_next   = '0;
                            rd_addr    = '0;
                            state_next = S_EX;
                        end
                        CMD_SETUP, CMD_GIVE, CMD_ENABLE, CMD_DISABLE:
                        begin
                            if (in_range)
                            begin
                                idx_next   = ent_w[IDX_W-1:0];
                                rd_addr    = ent_w[IDX_W-1:0];
                                state_next = S_EX;
                            end
                            else
                            begin
                                // Entry beyond the table: report it, change nothing.
                                hold_valid_next = 1'b1;
                                state_next      = S_FINAL;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end
            S_EX:
            begin
                if (!sweep)
                begin
                    hold_valid_next  = 1'b1;
                    hold_status_next = upd.refused;
                    hold_rem_next    = rem_w[VAL_W-1:0];
                    state_next       = S_FINAL;
                end
                else if (!ex_stall)
                begin
                    if (upd.fire)
                    begin
                        // The earlier fire is not the last one: pass it on.
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_entry_next  = hold_entry_reg;
                            out_fired_next  = hold_fired_reg;
                            out_status_next = hold_status_reg;
                            out_rem_next    = hold_rem_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_entry_next  = idx_w[ENTRY_W-1:0];
                        hold_fired_next  = 1'b1;
                        hold_status_next = 1'b0;
                        hold_rem_next    = rem_w[VAL_W-1:0];
                        fire_cnt_next    = fire_cnt_reg + FIRE_CNT_W'(1);
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = hold_valid_reg ? hold_entry_reg : '0;
                    out_fired_next  = hold_valid_reg && hold_fired_reg;
                    out_status_next = hold_valid_reg && hold_status_reg;
                    out_rem_next    = hold_valid_reg ? hold_rem_reg : '0;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fire_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        mode_reg        <= mode_next;
        start_reg       <= start_next;
        ceil_reg        <= ceil_next;
        reload_reg      <= reload_next;
        idx_reg         <= idx_next;
        hold_entry_reg  <= hold_entry_next;
        hold_fired_reg  <= hold_fired_next;
        hold_status_reg <= hold_status_next;
        hold_rem_reg    <= hold_rem_next;
        out_entry_reg   <= out_entry_next;
        out_fired_reg   <= out_fired_next;
        out_status_reg  <= out_status_next;
        out_rem_reg     <= out_rem_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign fired_entry = out_entry_reg;
    assign fired       = out_fired_reg;
    assign status      = out_status_reg;
    assign remaining   = out_rem_reg;
    assign last        = out_last_reg;

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fire_cnt_reg) <= 32'(MAX_RESULTS))
        else $error("more fires than a consume may report");

    a_write_in_ex: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EX))
        else $error("store written outside the update state");

    a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EX) && ex_stall) |=> (idx_reg == $past(idx_reg)))
        else $error("sweep moved on while a fire was held back");

    a_fire_no_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg) |-> !out_status_reg)
        else $error("fire word reports a refused give");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINAL) && out_free) |=> (state_reg == S_IDLE) && out_last_reg)
        else $error("final word not delivered on leaving the final state");

endmodule
